// ===== design/descriptor_ring_chain_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Descriptor ring assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_RING_CHAIN_QUEUE_DEFINES_SVH
`define DESCRIPTOR_RING_CHAIN_QUEUE_DEFINES_SVH

// same-cycle implication
`define DRCQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descriptor ring assertion failed");

// next-cycle implication
`define DRCQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descriptor ring assertion failed");

`endif

// ===== design/drcq_pkg.sv =====
// ----------------------------------------------------------------------------
// Descriptor ring package
// Ring geometry, descriptor layout, command and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drcq_pkg;

	// ring geometry
	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int EXT_W      = (PTR_W > 8) ? PTR_W : 8;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// flag bit that chains to the following entry
	localparam int NEXT_BIT = 0;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [63:0] offset;
		logic [31:0] length;
		logic [15:0] flags;
		logic [15:0] region;
	} entry_t;

	// advance a ring pointer with wrap at the ring depth
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// low eight bits of a slot number
	function automatic logic [7:0] slot_of(input ptr_t p);
		logic [EXT_W-1:0] e;
		e = EXT_W'(p);
		return e[7:0];
	endfunction

endpackage

// ===== design/ring_if.sv =====
// ----------------------------------------------------------------------------
// Descriptor ring channels
// Request and response channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ring_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] buffer_offset;
	logic [31:0] buffer_length;
	logic [15:0] descriptor_flags;
	logic [15:0] region_id;

	modport source (
		output valid, command, buffer_offset, buffer_length, descriptor_flags, region_id,
		input  ready
	);
	modport sink (
		input  valid, command, buffer_offset, buffer_length, descriptor_flags, region_id,
		output ready
	);
endinterface

interface ring_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] slot_index;
	logic [7:0] freed_count;

	modport source (
		output valid, status, slot_index, freed_count,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, freed_count,
		output ready
	);
endinterface

// ===== design/descriptor_ring_chain_queue.sv =====
// ----------------------------------------------------------------------------
// Descriptor ring with chained pop
// Circular ring of buffer descriptors held in one synchronous memory.
//
// Channels: req carries push (command 0, with the descriptor fields) or
// pop (command 1); rsp returns one status / slot / freed count per request.
// A push writes the descriptor at the tail in the accept cycle; its
// response is registered and valid in the cycle after the transfer, and
// pushes can follow each other every cycle while rsp does not stall. A full
// push or empty pop answers the same way without touching the ring.
// A pop walks the chain from the head, one entry per cycle: the memory
// read issued at accept returns in the next cycle, and each walk cycle tests
// the next flag, clears the entry and reads the following one. The walk
// ends at an unchained entry or when the ring drains, and the response
// is loaded then, or held in S_FIN until the output register is free.
// Reset clears the head and tail pointers and the response valid; the
// descriptor memory needs no clearing since only pushed entries are read.
// When rsp stalls, the pending response is held and req is not ready until
// the output register can take the next response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descriptor_ring_chain_queue_defines.svh"

module descriptor_ring_chain_queue (
	input  logic        clk,
	input  logic        arst_n,
	ring_req_if.sink    req,
	ring_rsp_if.source  rsp
);
	import drcq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} state_t;

	state_t     state_q;
	ptr_t       head_q;
	ptr_t       tail_q;
	ptr_t       idx_q;
	logic [7:0] slot_q;
	logic [7:0] freed_q;

	logic       rsp_valid_q;
	logic [1:0] rsp_status_q;
	logic [7:0] rsp_slot_q;
	logic [7:0] rsp_freed_q;

	entry_t     mem [RING_DEPTH];
	entry_t     rdata_q;

	logic       out_free;
	logic       in_acc;
	ptr_t       tail_nx;
	ptr_t       idx_nx;
	logic       full;
	logic       empty;
	logic       walk_go;
	logic [7:0] freed_inc;
	logic       rsp_load;
	logic       mem_we;
	ptr_t       mem_waddr;
	ptr_t       mem_raddr;
	entry_t     mem_wdata;

	// handshake and ring status
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign in_acc    = req.valid && req.ready;
	assign tail_nx   = ptr_next(tail_q);
	assign full      = (tail_nx == head_q);
	assign empty     = (head_q == tail_q);

	// chain walk: continue while the entry just read is chained and ring not drained
	assign idx_nx    = ptr_next(idx_q);
	assign walk_go   = rdata_q.flags[NEXT_BIT] && (idx_nx != tail_q);
	assign freed_inc = (freed_q == 8'hFF) ? freed_q : freed_q + 8'd1;

	// a new response enters the output register this cycle
	assign rsp_load = ((state_q == S_IDLE) && in_acc && ((req.command == CMD_PUSH) || empty))
		|| ((state_q == S_WALK) && !walk_go && out_free)
		|| ((state_q == S_FIN) && out_free);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.slot_index  = rsp_slot_q;
	assign rsp.freed_count = rsp_freed_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = '{offset: req.buffer_offset, length: req.buffer_length,
			flags: req.descriptor_flags, region: req.region_id};
		mem_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				mem_we = in_acc && (req.command == CMD_PUSH) && !full;
			end
			S_WALK: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
				mem_raddr = idx_nx;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// descriptor memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// control state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req.command == CMD_PUSH) begin
							rsp_freed_q <= 8'd0;
							if (full) begin
								rsp_status_q <= ST_FULL;
								rsp_slot_q   <= 8'd0;
							end else begin
								rsp_status_q <= ST_OK;
								rsp_slot_q   <= slot_of(tail_q);
								tail_q       <= tail_nx;
							end
						end else if (empty) begin
							rsp_status_q <= ST_EMPTY;
							rsp_slot_q   <= 8'd0;
							rsp_freed_q  <= 8'd0;
						end else begin
							idx_q   <= head_q;
							slot_q  <= slot_of(head_q);
							freed_q <= 8'd0;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					idx_q   <= idx_nx;
					freed_q <= freed_inc;
					if (!walk_go) begin
						head_q <= idx_nx;
						if (out_free) begin
							rsp_status_q <= ST_OK;
							rsp_slot_q   <= slot_q;
							rsp_freed_q  <= freed_inc;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						rsp_status_q <= ST_OK;
						rsp_slot_q   <= slot_q;
						rsp_freed_q  <= freed_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`DRCQ_ASSERT_IMPL(a_walk_before_tail, state_q == S_WALK, idx_q != tail_q)
	`DRCQ_ASSERT_IMPL(a_walk_nonempty, state_q == S_WALK, head_q != tail_q)
	`DRCQ_ASSERT_IMPL(a_fin_holds_rsp, state_q == S_FIN, rsp_valid_q)
	`DRCQ_ASSERT_NEXT(a_push_advances, in_acc && (req.command == CMD_PUSH) && !full, tail_q == ptr_next($past(tail_q)))

endmodule
